FILE: src/kway_merge_dedup_macros.svh
// assertion helpers for the merge block
// both macros sample on clk and are disabled while rst is high
`ifndef KWAY_MERGE_DEDUP_MACROS_SVH
`define KWAY_MERGE_DEDUP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KMD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kway_merge_dedup check failed");
// next-cycle implication
`define KMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kway_merge_dedup check failed");
`else
`define KMD_ASSERT(label, ante, cons)
`define KMD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/kmd_pkg.sv
`default_nettype none

package kmd_pkg;

  // fixed field widths of the channels and the configuration register
  localparam int WAY_W    = 3;
  localparam int KEY_W    = 64;
  localparam int WAYS_CFG_W = 4;

  // defaults for the top level parameters
  localparam int NUM_WAYS_DEF = 8;
  localparam int KEY_BITS_DEF = 64;

  // reset value of the ways_in_use register
  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd8;

endpackage

`default_nettype wire

FILE: src/kmd_in_if.sv
`default_nettype none

interface kmd_in_if import kmd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WAY_W-1:0] way;
  logic [KEY_W-1:0] key;
  logic             end_of_way;

  modport source (output valid, output way, output key, output end_of_way, input ready);
  modport sink   (input valid, input way, input key, input end_of_way, output ready);
endinterface

`default_nettype wire

FILE: src/kmd_out_if.sv
`default_nettype none

interface kmd_out_if import kmd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_new;
  logic [KEY_W-1:0] merged_key;
  logic [WAY_W-1:0] need_way;
  logic             finished;

  modport source (output valid, output is_new, output merged_key, output need_way,
                  output finished, input ready);
  modport sink   (input valid, input is_new, input merged_key, input need_way,
                  input finished, output ready);
endinterface

`default_nettype wire

FILE: src/kway_merge_dedup.sv
`default_nettype none
`include "kway_merge_dedup_macros.svh"

// K-way merge with duplicate removal. Each request on in_stream loads the next head key
// of one way or marks that way exhausted; once every way in use (ways 0 .. ways_in_use-1,
// a register value of 0 acting as 1 and values above NUM_WAYS as NUM_WAYS) holds a head
// or is exhausted, the smallest head is popped (ties to the lowest way) and one result
// goes out with is_new low for a repeat of the last new key and need_way naming the way
// to feed next. When all ways in use are exhausted a single result with finished high
// is sent and the merge state clears for the next merge; ways_in_use is kept. Requests
// for ways out of use, already loaded or already exhausted are dropped without a result. The
// block takes one request per cycle unless a held result waits for out_stream.ready; a
// request passes the input register, then the result register, and the path between them
// is the registered-head minimum tree of depth log2(NUM_WAYS) comparators of KEY_BITS bits.
// ways_in_use may only be written while no request is in flight.
module kway_merge_dedup import kmd_pkg::*; #(
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [WAYS_CFG_W-1:0] cfg_wdata,
  kmd_in_if.sink                     in_stream,
  kmd_out_if.source                  out_stream
);

  localparam int IDXW = $clog2(NUM_WAYS);
  localparam int LEAVES = 1 << IDXW;
  localparam logic [4:0] NW5 = 5'(NUM_WAYS);

  typedef struct packed {
    logic                vld;
    logic [KEY_BITS-1:0] key;
    logic [IDXW-1:0]     idx;
  } cand_t;

  // configuration register
  logic [WAYS_CFG_W-1:0] ways_in_use;

  // input register
  logic                s1_valid;
  logic [WAY_W-1:0]    s1_way;
  logic [KEY_BITS-1:0] s1_key;
  logic                s1_eow;

  // merge state
  logic [KEY_BITS-1:0] head_key [NUM_WAYS];
  logic [NUM_WAYS-1:0] head_valid, head_valid_next;
  logic [NUM_WAYS-1:0] stream_done, stream_done_next;
  logic [KEY_BITS-1:0] last_emitted, last_emitted_next;
  logic                any_emitted, any_emitted_next;

  // result register
  logic                o_valid;
  logic                o_is_new;
  logic [KEY_BITS-1:0] o_key;
  logic [WAY_W-1:0]    o_need_way;
  logic                o_finished;

  // combinational results of the single pass
  logic [4:0]          n_act;
  logic [NUM_WAYS-1:0] in_use, load_sel, hv1, sd1;
  logic                skip, all_ready, res_valid, res_fin, res_new;
  logic [KEY_BITS-1:0] res_key;
  logic [IDXW-1:0]     res_idx;
  logic                s1_go;
  cand_t               node [1:2*LEAVES-1];

  assign s1_go = s1_valid && (!o_valid || out_stream.ready);
  assign in_stream.ready = !s1_valid || s1_go;

  // effective number of ways and per-way masks
  always_comb begin
    if (ways_in_use == '0) begin
      n_act = 5'd1;
    end else if ({1'b0, ways_in_use} > NW5) begin
      n_act = NW5;
    end else begin
      n_act = {1'b0, ways_in_use};
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      in_use[i]   = 5'(i) < n_act;
      load_sel[i] = {2'b00, s1_way} == 5'(i);
    end
    skip = !({2'b00, s1_way} < n_act) || |(load_sel & (head_valid | stream_done));
    hv1  = head_valid  | (skip || s1_eow  ? '0 : load_sel);
    sd1  = stream_done | (skip || !s1_eow ? '0 : load_sel);
    all_ready = &(hv1 | sd1 | ~in_use);
  end

  // minimum tree over the heads, new key included; left wins ties
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < NUM_WAYS) begin
        node[LEAVES+i].vld = hv1[i] && in_use[i];
        node[LEAVES+i].key = load_sel[i] ? s1_key : head_key[i];
      end else begin
        node[LEAVES+i].vld = 1'b0;
        node[LEAVES+i].key = '0;
      end
      node[LEAVES+i].idx = IDXW'(i);
    end
    for (int j = LEAVES - 1; j >= 1; j--) begin
      if (node[2*j+1].vld && (!node[2*j].vld || node[2*j+1].key < node[2*j].key)) begin
        node[j] = node[2*j+1];
      end else begin
        node[j] = node[2*j];
      end
    end
    res_key = node[1].key;
    res_idx = node[1].idx;
  end

  // result and next merge state
  always_comb begin
    res_valid         = !skip && all_ready;
    res_fin           = res_valid && !node[1].vld;
    res_new           = !any_emitted || (res_key != last_emitted);
    head_valid_next   = head_valid;
    stream_done_next  = stream_done;
    last_emitted_next = last_emitted;
    any_emitted_next  = any_emitted;
    if (!skip) begin
      head_valid_next  = hv1;
      stream_done_next = sd1;
      if (res_fin) begin
        head_valid_next   = '0;
        stream_done_next  = '0;
        last_emitted_next = '0;
        any_emitted_next  = 1'b0;
      end else if (res_valid) begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (IDXW'(i) == res_idx) begin
            head_valid_next[i] = 1'b0;
          end
        end
        if (res_new) begin
          last_emitted_next = res_key;
          any_emitted_next  = 1'b1;
        end
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= WAYS_RESET;
    end else if (cfg_we) begin
      ways_in_use <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_stream.ready) begin
      s1_valid <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      s1_way <= in_stream.way;
      s1_key <= in_stream.key[KEY_BITS-1:0];
      s1_eow <= in_stream.end_of_way;
    end
  end

  // head keys, written when a way is loaded
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (s1_go && !skip && !s1_eow && load_sel[i]) begin
        head_key[i] <= s1_key;
      end
    end
  end

  // merge control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid   <= '0;
      stream_done  <= '0;
      last_emitted <= '0;
      any_emitted  <= 1'b0;
    end else if (s1_go) begin
      head_valid   <= head_valid_next;
      stream_done  <= stream_done_next;
      last_emitted <= last_emitted_next;
      any_emitted  <= any_emitted_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_go && res_valid) begin
      o_valid <= 1'b1;
    end else if (out_stream.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      o_finished <= res_fin;
      o_is_new   <= !res_fin && res_new;
      o_key      <= res_fin ? '0 : res_key;
      o_need_way <= res_fin ? '0 : WAY_W'(res_idx);
    end
  end

  assign out_stream.valid      = o_valid;
  assign out_stream.is_new     = o_is_new;
  assign out_stream.merged_key = KEY_W'(o_key);
  assign out_stream.need_way   = o_need_way;
  assign out_stream.finished   = o_finished;

  // checks
  `KMD_ASSERT(a_no_head_and_done, 1'b1, (head_valid & stream_done) == '0)
  `KMD_ASSERT_NEXT(a_finish_clears, s1_go && res_fin,
                   head_valid == '0 && stream_done == '0 && !any_emitted)
  `KMD_ASSERT_NEXT(a_result_held, o_valid && !out_stream.ready, o_valid)
  `KMD_ASSERT(a_dup_matches_last, o_valid && !o_finished && !o_is_new,
              any_emitted && o_key == last_emitted)

endmodule

`default_nettype wire

FILE: test/kway_merge_dedup_test.sv
`timescale 1ns / 1ps

module kway_merge_dedup_test import kmd_pkg::*; ();

  localparam int NUM_WAYS = NUM_WAYS_DEF;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  // a result passes the input and result registers after its request; allow some slack
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 500;

  typedef struct packed {
    logic             is_new;
    logic [KEY_W-1:0] merged_key;
    logic [WAY_W-1:0] need_way;
    logic             finished;
  } merge_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [WAYS_CFG_W-1:0] ways_val;
    logic [WAY_W-1:0]      way;
    logic [KEY_W-1:0]      key;
    logic                  end_of_way;
    logic                  typed;
    merge_res_t            res;
  } dir_row_t;

  localparam merge_res_t NO_RES  = '0;
  localparam merge_res_t FIN_RES = '{1'b0, 64'd0, 3'd0, 1'b1};

  // directed rows: all-empty merge at reset width, then two ways, then one way, then a write of 15
  localparam int DIR_COUNT = 24;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{ROW_ITEM, 4'd0,  3'd0, 64'd0, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 64'd0, 1'b1, 1'b0, NO_RES},  // already exhausted
    '{ROW_ITEM, 4'd0,  3'd1, 64'd0, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd2, 64'd0, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd3, 64'd0, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd4, 64'd0, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd5, 64'd0, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd6, 64'd0, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd7, KEY_MAX, 1'b1, 1'b1, FIN_RES},  // all streams empty
    '{ROW_CFG,  4'd2,  3'd0, 64'd0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd2, 64'd5, 1'b0, 1'b0, NO_RES},  // way not in use
    '{ROW_ITEM, 4'd0,  3'd0, KEY_MAX, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 64'd3, 1'b0, 1'b0, NO_RES},  // head already loaded
    '{ROW_ITEM, 4'd0,  3'd1, 64'd0, 1'b0, 1'b1, '{1'b1, 64'd0, 3'd1, 1'b0}},
    '{ROW_ITEM, 4'd0,  3'd1, KEY_MAX, 1'b0, 1'b1, '{1'b1, KEY_MAX, 3'd0, 1'b0}},  // tie
    '{ROW_ITEM, 4'd0,  3'd0, 64'd0, 1'b1, 1'b1, '{1'b0, KEY_MAX, 3'd1, 1'b0}},  // repeat
    '{ROW_ITEM, 4'd0,  3'd1, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0, NO_RES},  // out of order
    '{ROW_ITEM, 4'd0,  3'd1, 64'd0, 1'b1, 1'b1, FIN_RES},
    '{ROW_CFG,  4'd0,  3'd0, 64'd0, 1'b0, 1'b0, NO_RES},  // zero acts as one way
    '{ROW_ITEM, 4'd0,  3'd1, 64'd1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 64'd0, 1'b0, 1'b1, '{1'b1, 64'd0, 3'd0, 1'b0}},  // first key
    '{ROW_ITEM, 4'd0,  3'd0, 64'd0, 1'b0, 1'b1, '{1'b0, 64'd0, 3'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  3'd0, 64'd0, 1'b1, 1'b1, FIN_RES},
    '{ROW_CFG,  4'd15, 3'd0, 64'd0, 1'b0, 1'b0, NO_RES}   // above range acts as eight
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [WAYS_CFG_W-1:0] cfg_wdata;

  kmd_in_if  in_if ();
  kmd_out_if out_if ();

  kway_merge_dedup dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  // predictor state
  logic [WAYS_CFG_W-1:0] ways_cfg;
  logic [KEY_W-1:0]      head_k [NUM_WAYS];
  bit                    head_v [NUM_WAYS];
  bit                    done_q [NUM_WAYS];
  logic [KEY_W-1:0]      last_new;
  bit                    any_new;

  merge_res_t merged_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_cnt;
  int taken_cnt;
  int ignored_cnt;
  int result_cnt;
  int finished_cnt;
  int dup_cnt;
  int cfg_cnt;

  // per-merge stimulus streams
  logic [KEY_W-1:0] stream_key [NUM_WAYS][8];
  int               stream_len [NUM_WAYS];
  int               stream_pos [NUM_WAYS];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous run limit
  initial begin
    #2_000_000;
    $display("kway_merge_dedup_test failed");
    $finish;
  end

  function automatic int active_ways();
    if (ways_cfg == '0) return 1;
    if (ways_cfg > NUM_WAYS) return NUM_WAYS;
    return int'(ways_cfg);
  endfunction

  function automatic void clear_merge_state();
    for (int i = 0; i < NUM_WAYS; i++) begin
      head_v[i] = 1'b0;
      done_q[i] = 1'b0;
    end
    last_new = '0;
    any_new  = 1'b0;
  endfunction

  function automatic bit way_open(input logic [WAY_W-1:0] w);
    return (int'(w) < active_ways()) && !head_v[w] && !done_q[w];
  endfunction

  // expected merge result for one accepted request
  function automatic void merge_predict(input logic [WAY_W-1:0] w,
                                        input logic [KEY_W-1:0] k,
                                        input logic eow,
                                        output bit taken,
                                        output bit got,
                                        output merge_res_t r);
    int n;
    int best;
    bit found;
    n = active_ways();
    best = 0;
    found = 1'b0;
    taken = 1'b0;
    got = 1'b0;
    r = '0;
    if (!way_open(w)) return;
    taken = 1'b1;
    if (eow) begin
      done_q[w] = 1'b1;
    end else begin
      head_k[w] = k;
      head_v[w] = 1'b1;
    end
    // wait until every way in use is loaded or exhausted
    for (int i = 0; i < n; i++) begin
      if (!head_v[i] && !done_q[i]) return;
    end
    got = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (head_v[i] && (!found || head_k[i] < head_k[best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.finished = 1'b1;
      clear_merge_state();
      return;
    end
    r.merged_key = head_k[best];
    r.need_way   = WAY_W'(best);
    r.is_new     = !any_new || head_k[best] != last_new;
    head_v[best] = 1'b0;
    if (r.is_new) begin
      last_new = head_k[best];
      any_new  = 1'b1;
    end
  endfunction

  // one request on the input channel, with random sender gaps
  task automatic push_request(input logic [WAY_W-1:0] w, input logic [KEY_W-1:0] k,
                              input logic eow, input bit typed, input merge_res_t typed_res,
                              output bit got, output merge_res_t r);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.way        = w;
    in_if.key        = k;
    in_if.end_of_way = eow;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    merge_predict(w, k, eow, taken, got, r);
    if (typed) begin
      got = 1'b1;
      r   = typed_res;
    end
    if (got) merged_q = {merged_q, r};
    if (taken) taken_cnt++;
    else ignored_cnt++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_drain();
    while (merged_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only once nothing is in flight
  task automatic write_ways(input logic [WAYS_CFG_W-1:0] v);
    wait_drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    ways_cfg  = v;
    cfg_cnt++;
  endtask

  // next key of a way, or its end mark once the stream runs dry
  task automatic feed_way(input int w, output bit got, output merge_res_t r);
    if (stream_pos[w] < stream_len[w]) begin
      push_request(WAY_W'(w), stream_key[w][stream_pos[w]], 1'b0, 1'b0, NO_RES, got, r);
      stream_pos[w]++;
    end else begin
      push_request(WAY_W'(w), {$urandom, $urandom}, 1'b1, 1'b0, NO_RES, got, r);
    end
  endtask

  // occasional request that the block must drop
  task automatic maybe_noise();
    logic [WAY_W-1:0] w;
    bit got;
    merge_res_t r;
    w = WAY_W'($urandom_range(NUM_WAYS - 1));
    if ($urandom_range(9) == 0 && !way_open(w))
      push_request(w, {$urandom, $urandom}, 1'($urandom_range(1)), 1'b0, NO_RES, got, r);
  endtask

  // one complete merge with random ascending streams
  task automatic run_merge();
    int n;
    int order [NUM_WAYS];
    int j;
    int tmp;
    int style;
    bit empty_all;
    bit got;
    merge_res_t r;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] cur;
    logic [KEY_W-1:0] nxt;
    logic [KEY_W-1:0] step;
    n = active_ways();
    style = $urandom_range(2);
    empty_all = ($urandom_range(9) == 0);
    base = {$urandom, $urandom};
    r = NO_RES;
    for (int w = 0; w < n; w++) begin
      stream_len[w] = empty_all ? 0 : $urandom_range(6);
      stream_pos[w] = 0;
      case (style)
        0: begin
          // dense keys, many repeats across ways
          cur  = base + 64'($urandom_range(3));
          step = 64'($urandom_range(2));
        end
        1: begin
          cur  = {$urandom, $urandom} >> $urandom_range(1, 16);
          step = {$urandom, $urandom} >> $urandom_range(8, 40);
        end
        default: begin
          // keys pinned at the ends of the range
          cur  = $urandom_range(1) ? '0 : KEY_MAX - 64'($urandom_range(3));
          step = $urandom_range(1) ? '0 : {$urandom, $urandom};
        end
      endcase
      for (int i = 0; i < stream_len[w]; i++) begin
        stream_key[w][i] = ($urandom_range(15) == 0) ? {$urandom, $urandom} : cur;
        nxt = cur + step;
        cur = (nxt < cur) ? KEY_MAX : nxt;
      end
    end
    // first heads in random order
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      maybe_noise();
      feed_way(order[i], got, r);
    end
    // then follow need_way until completion
    while (!r.finished) begin
      maybe_noise();
      feed_way(int'(r.need_way), got, r);
    end
  endtask

  function automatic void report_field(input string name, input logic [KEY_W-1:0] want,
                                       input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // receiver with random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    merge_res_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      result_cnt++;
      if (out_if.finished === 1'b1) finished_cnt++;
      else if (out_if.is_new === 1'b0) dup_cnt++;
      if (merged_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual key %0h way %0d fin %0b",
                 $time, out_if.merged_key, out_if.need_way, out_if.finished);
        fail_cnt++;
      end else begin
        want = merged_q.pop_front();
        report_field("is_new", KEY_W'(want.is_new), KEY_W'(out_if.is_new));
        report_field("merged_key", want.merged_key, out_if.merged_key);
        report_field("need_way", KEY_W'(want.need_way), KEY_W'(out_if.need_way));
        report_field("finished", KEY_W'(want.finished), KEY_W'(out_if.finished));
      end
    end
  end

  // main sequence
  initial begin : stimulus
    bit got;
    merge_res_t r;
    int phase_start;
    bit first_merge;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.way        = '0;
    in_if.key        = '0;
    in_if.end_of_way = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    fail_cnt         = 0;
    taken_cnt        = 0;
    ignored_cnt      = 0;
    result_cnt       = 0;
    finished_cnt     = 0;
    dup_cnt          = 0;
    cfg_cnt          = 0;
    ways_cfg         = WAYS_RESET;
    clear_merge_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_ways(DIR_ROWS[i].ways_val);
      end else begin
        push_request(DIR_ROWS[i].way, DIR_ROWS[i].key, DIR_ROWS[i].end_of_way,
                     DIR_ROWS[i].typed, DIR_ROWS[i].res, got, r);
      end
    end

    // random merges under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = taken_cnt;
      first_merge = 1'b1;
      while (taken_cnt - phase_start < PHASE_ITEMS) begin
        if (first_merge) begin
          write_ways(phase == 0 ? 4'd15 : (phase == 1 ? 4'd1 : 4'd0));
          first_merge = 1'b0;
        end else if ($urandom_range(2) == 0) begin
          write_ways(WAYS_CFG_W'($urandom_range(15)));
        end
        run_merge();
      end
    end

    wait_drain();
    $display("summary: %0d requests merged, %0d dropped, %0d register writes",
             taken_cnt, ignored_cnt, cfg_cnt);
    $display("summary: %0d results checked, %0d merges completed, %0d repeats removed",
             result_cnt, finished_cnt, dup_cnt);
    if (fail_cnt == 0) begin
      $display("kway_merge_dedup_test passed");
    end else begin
      $display("kway_merge_dedup_test failed");
    end
    $finish;
  end

endmodule
